>>> rtl/core/acef_pkg.sv
// ----------------------------------------------------------------------------
// acef_pkg - shared types and constants for the ANSI colour escape filter
// Parser mode encoding, character codes and default widths.
// ----------------------------------------------------------------------------
package acef_pkg;

    // Fixed field widths
    localparam int CP_W    = 21;
    localparam int COLOR_W = 3;

    // Default parameter value width
    localparam int PARAM_WIDTH_DEF = 16;

    // Parser modes
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_CSI   = 2'd2,
        MODE_OSC   = 2'd3
    } mode_t;

    // Character codes
    localparam logic [CP_W-1:0] CH_BEL    = CP_W'(7);
    localparam logic [CP_W-1:0] CH_CR     = CP_W'(13);
    localparam logic [CP_W-1:0] CH_ESC    = CP_W'(27);
    localparam logic [CP_W-1:0] CH_SEMI   = CP_W'(59);
    localparam logic [CP_W-1:0] CH_LBRACK = CP_W'(91);
    localparam logic [CP_W-1:0] CH_RBRACK = CP_W'(93);
    localparam logic [CP_W-1:0] CH_DIG0   = CP_W'(48);
    localparam logic [CP_W-1:0] CH_DIG9   = CP_W'(57);
    localparam logic [CP_W-1:0] CH_UPA    = CP_W'(65);
    localparam logic [CP_W-1:0] CH_UPZ    = CP_W'(90);
    localparam logic [CP_W-1:0] CH_LOA    = CP_W'(97);
    localparam logic [CP_W-1:0] CH_LOZ    = CP_W'(122);

    // Foreground colour parameter range
    localparam int COLOR_LOW  = 30;
    localparam int COLOR_HIGH = 37;

    // Number of CSI parameters kept; slot count saturates here
    localparam int NUM_PARAMS = 3;

endpackage

>>> rtl/core/ansi_color_escape_filter_core.sv
// ----------------------------------------------------------------------------
// ansi_color_escape_filter_core - ANSI escape stripper with colour tagging
// Removes CSI and OSC escape sequences from a code point stream and tags
// each plain character with the foreground colour set by SGR parameters.
// ----------------------------------------------------------------------------
// The block accepts one code point every clock cycle unless in_stall is high and
// presents at most one plain character per code point on the result channel,
// through the input register and then the result register. The input register
// feeds a single stage of parser logic
// (mode, parameter slot, three saturating decimal accumulators and the
// colour) which writes the result register; an output stall holds the result
// register and, through it, the input register. Configuration writes are
// always ready and take effect on the next code point processed.
module ansi_color_escape_filter_core #(
    parameter int PARAM_WIDTH = acef_pkg::PARAM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input word channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [acef_pkg::CP_W-1:0]     code_point,
    input  logic                          end_of_chunk,
    // result word channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [acef_pkg::CP_W-1:0]     char_out,
    output logic [acef_pkg::COLOR_W-1:0]  color,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);
    import acef_pkg::*;

    localparam int SLOT_W = 2;
    localparam int MUL_W  = PARAM_WIDTH + 4;

    typedef logic [PARAM_WIDTH-1:0] param_t;

    // Configuration
    logic drop_cr_reg;

    // Input register
    logic            in_vld_reg;
    logic [CP_W-1:0] cp_reg;
    logic            eoc_reg;

    // Parser state
    mode_t               mode_reg, mode_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    param_t              params_reg [NUM_PARAMS];
    param_t              params_next [NUM_PARAMS];
    logic [COLOR_W-1:0]  color_reg, color_next;

    // Result register
    logic               out_vld_reg, out_vld_next;
    logic [CP_W-1:0]    char_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic               emit;
    logic               out_free;
    logic               advance;
    logic               is_digit, is_letter;
    param_t             acc_sel;
    logic [MUL_W-1:0]   acc_mul;
    param_t             acc_sat;
    logic [COLOR_W-1:0] sgr_color;

    // Handshake control
    assign out_free  = !out_vld_reg || !out_stall;
    assign advance   = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign cfg_ready = 1'b1;

    assign out_valid = out_vld_reg;
    assign char_out  = char_reg;
    assign color     = out_color_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_cr_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            drop_cr_reg <= cfg_data;
        end
    end

    // Input register: load whenever empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cp_reg  <= code_point;
            eoc_reg <= end_of_chunk;
        end
    end

    // Character classes
    assign is_digit  = (cp_reg >= CH_DIG0) && (cp_reg <= CH_DIG9);
    assign is_letter = ((cp_reg >= CH_UPA) && (cp_reg <= CH_UPZ)) ||
                       ((cp_reg >= CH_LOA) && (cp_reg <= CH_LOZ));

    // Accumulate one decimal digit into the selected parameter, saturating
    always_comb
    begin
        acc_sel = params_reg[slot_reg];
        acc_mul = (MUL_W'(acc_sel) << 3) + (MUL_W'(acc_sel) << 1) +
                  MUL_W'(cp_reg[3:0]);
        if (|acc_mul[MUL_W-1:PARAM_WIDTH])
        begin
            acc_sat = '1;
        end
        else
        begin
            acc_sat = acc_mul[PARAM_WIDTH-1:0];
        end
    end

    // Colour chosen by the SGR parameters at the end of a sequence
    always_comb
    begin
        sgr_color = color_reg;
        if (params_reg[0] == '0)
        begin
            sgr_color = '0;
        end
        else
        begin
            for (int k = 0; k < NUM_PARAMS; k++)
            begin
                if ((params_reg[k] >= PARAM_WIDTH'(COLOR_LOW)) &&
                    (params_reg[k] <= PARAM_WIDTH'(COLOR_HIGH)))
                begin
                    sgr_color = COLOR_W'(params_reg[k] - PARAM_WIDTH'(COLOR_LOW));
                end
            end
        end
    end

    // Next state of the parser
    always_comb
    begin
        mode_next   = mode_reg;
        slot_next   = slot_reg;
        params_next = params_reg;
        color_next  = color_reg;
        case (mode_reg)
            MODE_PLAIN:
            begin
                if (cp_reg == CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
            end
            MODE_ESC:
            begin
                if (cp_reg == CH_LBRACK)
                begin
                    mode_next = MODE_CSI;
                    slot_next = '0;
                    for (int k = 0; k < NUM_PARAMS; k++)
                    begin
                        params_next[k] = '0;
                    end
                end
                else if (cp_reg == CH_RBRACK)
                begin
                    mode_next = MODE_OSC;
                end
                else
                begin
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_CSI:
            begin
                if (cp_reg == CH_SEMI)
                begin
                    if (slot_reg != SLOT_W'(NUM_PARAMS))
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                else if (is_digit)
                begin
                    if (slot_reg != SLOT_W'(NUM_PARAMS))
                    begin
                        params_next[slot_reg] = acc_sat;
                    end
                end
                else if (is_letter)
                begin
                    color_next = sgr_color;
                    mode_next  = MODE_PLAIN;
                    slot_next  = '0;
                    for (int k = 0; k < NUM_PARAMS; k++)
                    begin
                        params_next[k] = '0;
                    end
                end
            end
            MODE_OSC:
            begin
                if (cp_reg == CH_BEL)
                begin
                    mode_next = MODE_PLAIN;
                end
            end
            default:
            begin
                mode_next = MODE_PLAIN;
            end
        endcase
        // Drop everything at the end of a chunk
        if (eoc_reg)
        begin
            mode_next  = MODE_PLAIN;
            slot_next  = '0;
            color_next = '0;
            for (int k = 0; k < NUM_PARAMS; k++)
            begin
                params_next[k] = '0;
            end
        end
    end

    // Result generation: plain characters pass unless a dropped carriage return
    always_comb
    begin
        emit = 1'b0;
        case (mode_reg)
            MODE_PLAIN:
            begin
                emit = (cp_reg != CH_ESC) && !((cp_reg == CH_CR) && drop_cr_reg);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (advance)
        begin
            out_vld_next = emit || (out_vld_reg && out_stall);
        end
        else
        begin
            out_vld_next = out_vld_reg && out_stall;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            slot_reg  <= '0;
            color_reg <= '0;
            for (int k = 0; k < NUM_PARAMS; k++)
            begin
                params_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            slot_reg   <= slot_next;
            color_reg  <= color_next;
            params_reg <= params_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            char_reg      <= cp_reg;
            out_color_reg <= color_reg;
        end
    end

    // Checks
    a_eoc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eoc_reg) |=> (mode_reg == MODE_PLAIN) && (color_reg == '0)
                                  && (slot_reg == '0))
        else $error("parser not cleared after end of chunk");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(advance && emit))
        else $error("result appeared without a processed plain character");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_escape_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (mode_reg != MODE_PLAIN)) |=>
            (out_vld_reg == $past(out_vld_reg && out_stall)))
        else $error("result produced inside an escape sequence");

    a_slot_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> ($stable(slot_reg) && $stable(color_reg)))
        else $error("parser state changed without an item");

endmodule

>>> sim/acef_stream_checker.sv
// ----------------------------------------------------------------------------
// acef_stream_checker - colour-tagging predictor and result comparison
// Watches the input, result and configuration channels of the ANSI colour
// escape filter, predicts each plain character with its colour and compares
// every result word in order against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module acef_stream_checker #(
    parameter int PARAM_WIDTH = acef_pkg::PARAM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [acef_pkg::CP_W-1:0]     code_point,
    input  logic                          end_of_chunk,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [acef_pkg::CP_W-1:0]     char_out,
    input  logic [acef_pkg::COLOR_W-1:0]  color,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_data,
    output int                            mismatch_count,
    output int                            chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import acef_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = '1;

    typedef struct packed {
        logic [CP_W-1:0]    ch;
        logic [COLOR_W-1:0] colour;
    } coloured_char_t;

    // Predicted parser state
    mode_t                  parse_mode;
    logic [1:0]             param_slot;
    logic [PARAM_WIDTH-1:0] params [NUM_PARAMS];
    logic [COLOR_W-1:0]     fg_colour;
    logic                   drop_cr;
    coloured_char_t         expected_chars [$];

    // Abandon any open sequence and return to plain text
    function automatic void clear_sequence();
        parse_mode = MODE_PLAIN;
        param_slot = '0;
        foreach (params[k])
            params[k] = '0;
    endfunction

    // Advance the parser by one code point; returns 1 when a plain character
    // leaves the filter
    function automatic bit filter_code_point(input logic [CP_W-1:0] cp,
                                             input logic last,
                                             output coloured_char_t plain);
        logic [PARAM_WIDTH+3:0] grown;
        bit                     emitted;
        emitted = 1'b0;
        plain   = '0;
        case (parse_mode)
            MODE_PLAIN:
            begin
                if (cp == CH_ESC)
                    parse_mode = MODE_ESC;
                else if (!(cp == CH_CR && drop_cr))
                begin
                    plain.ch     = cp;
                    plain.colour = fg_colour;
                    emitted      = 1'b1;
                end
            end
            MODE_ESC:
            begin
                if (cp == CH_LBRACK)
                begin
                    clear_sequence();
                    parse_mode = MODE_CSI;
                end
                else if (cp == CH_RBRACK)
                    parse_mode = MODE_OSC;
                else
                    parse_mode = MODE_PLAIN;
            end
            MODE_CSI:
            begin
                if (cp == CH_SEMI)
                begin
                    if (param_slot < NUM_PARAMS)
                        param_slot = param_slot + 2'd1;
                end
                else if (cp >= CH_DIG0 && cp <= CH_DIG9)
                begin
                    // accumulate decimal digit, saturating at the field maximum
                    if (param_slot < NUM_PARAMS)
                    begin
                        grown = (PARAM_WIDTH+4)'(params[param_slot])
                                  * (PARAM_WIDTH+4)'(10)
                              + (PARAM_WIDTH+4)'(cp - CH_DIG0);
                        params[param_slot] = (grown > PARAM_MAX) ? PARAM_MAX
                                                                 : grown[PARAM_WIDTH-1:0];
                    end
                end
                else if ((cp >= CH_UPA && cp <= CH_UPZ) || (cp >= CH_LOA && cp <= CH_LOZ))
                begin
                    // final letter: first parameter zero resets, else last in range wins
                    if (params[0] == '0)
                        fg_colour = '0;
                    else
                        foreach (params[k])
                            if (params[k] >= COLOR_LOW && params[k] <= COLOR_HIGH)
                                fg_colour = COLOR_W'(params[k] - COLOR_LOW);
                    clear_sequence();
                end
            end
            default:
            begin
                if (cp == CH_BEL)
                    parse_mode = MODE_PLAIN;
            end
        endcase
        if (last)
        begin
            clear_sequence();
            fg_colour = '0;
        end
        return emitted;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Track configuration, compare result words, predict from input words
    always @(posedge clk or negedge rst_n)
    begin
        coloured_char_t plain;
        coloured_char_t oldest;
        if (!rst_n)
        begin
            clear_sequence();
            fg_colour = '0;
            drop_cr   = 1'b0;
            expected_chars.delete();
            mismatch_count = 0;
            chars_pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                drop_cr = cfg_data;

            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    flag_mismatch($sformatf("unexpected word: char_out %h color %0d",
                                            char_out, color));
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (char_out !== oldest.ch || color !== oldest.colour)
                        flag_mismatch($sformatf(
                            "char_out %h expected %h, color %0d expected %0d",
                            char_out, oldest.ch, color, oldest.colour));
                end
            end

            if (in_valid && !in_stall)
                if (filter_code_point(code_point, end_of_chunk, plain))
                    expected_chars.insert(expected_chars.size(), plain);

            chars_pending = expected_chars.size();
        end
    end

endmodule

>>> sim/tb_ansi_color_escape_filter_core.sv
// ----------------------------------------------------------------------------
// tb_ansi_color_escape_filter_core - stimulus and verdict for the escape filter
// Drives directed escape sequences, then random well-formed and broken CSI,
// OSC and plain text under each carriage return setting, with random input
// gaps and output stalls; the checker beside the block judges every word.
// ----------------------------------------------------------------------------
module tb_ansi_color_escape_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import acef_pkg::*;

    localparam int PHASE_WORDS = 160;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [CP_W-1:0]    code_point   = '0;
    logic               end_of_chunk = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [CP_W-1:0]    char_out;
    logic [COLOR_W-1:0] color;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic               cfg_data     = 1'b0;

    int                 mismatch_count;
    int                 chars_pending;
    int                 words_sent   = 0;
    int                 stall_left   = 0;
    bit                 quiet        = 1'b0;

    always #1 clk = ~clk;

    ansi_color_escape_filter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_point   (code_point),
        .end_of_chunk (end_of_chunk),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .color        (color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    acef_stream_checker #(
        .PARAM_WIDTH (PARAM_WIDTH_DEF)
    ) stream_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .code_point     (code_point),
        .end_of_chunk   (end_of_chunk),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_out       (char_out),
        .color          (color),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    // Stall the result channel in random bursts, none while quiet
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Present one word and hold it until accepted, then maybe idle a while
    task automatic send_word(input logic [CP_W-1:0] cp, input logic last);
        in_valid     <= 1'b1;
        code_point   <= cp;
        end_of_chunk <= last;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send_word(CP_W'(s[i]), last && (i == s.len() - 1));
    endtask

    // Hold off until every predicted character is out and the result channel has
    // been left unstalled, so words with no result have drained too
    task automatic wait_idle();
        int calm;
        calm = 0;
        in_valid <= 1'b0;
        while (chars_pending != 0)
            @(negedge clk);
        while (calm < 4)
        begin
            @(negedge clk);
            calm = out_stall ? 0 : calm + 1;
        end
    endtask

    task automatic write_drop_cr(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CP_W-1:0] random_text_char();
        case ($urandom_range(0, 11))
            0:       return CH_CR;
            1:       return CH_BEL;
            2:       return CP_W'($urandom_range(0, 1114111));
            3:       return CP_W'($urandom_range(128, 1114111));
            4:       return $urandom_range(0, 1) ? CP_W'(1114111) : '0;
            5:       return CP_W'($urandom_range(0, 31));
            default: return CP_W'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic logic chunk_end();
        return $urandom_range(0, 59) == 0;
    endfunction

    // Mostly well-formed sequences with random content, some broken or noise
    task automatic run_random_phase(input int count);
        int               stop_at;
        int               n_params;
        string            digits;
        logic [CP_W-1:0]  c;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    repeat ($urandom_range(1, 6))
                        send_word(random_text_char(), chunk_end());
                3, 4, 5, 6:
                begin
                    send_word(CH_ESC, chunk_end());
                    send_word(CH_LBRACK, chunk_end());
                    n_params = $urandom_range(0, 5);
                    for (int p = 0; p < n_params; p++)
                    begin
                        if (p != 0)
                            send_word(CH_SEMI, chunk_end());
                        if ($urandom_range(0, 7) == 0)
                            send_word(random_text_char(), chunk_end());
                        case ($urandom_range(0, 7))
                            0:       digits = "0";
                            1:       digits = "";
                            2:       digits = $sformatf("%0d", $urandom_range(0, 99));
                            3:       digits = $sformatf("%0d", $urandom_range(60000, 9999999));
                            4:       digits = $sformatf("0%0d", $urandom_range(30, 37));
                            default: digits = $sformatf("%0d", $urandom_range(30, 37));
                        endcase
                        send_text(digits, 1'b0);
                    end
                    // leave some sequences unterminated
                    if ($urandom_range(0, 11) != 0)
                    begin
                        if ($urandom_range(0, 4) < 3)
                            c = CP_W'("m");
                        else
                            c = ($urandom_range(0, 1) ? CH_UPA : CH_LOA)
                              + CP_W'($urandom_range(0, 25));
                        send_word(c, chunk_end());
                    end
                end
                7:
                begin
                    send_word(CH_ESC, chunk_end());
                    send_word(CH_RBRACK, chunk_end());
                    repeat ($urandom_range(0, 5))
                    begin
                        do
                            c = random_text_char();
                        while (c == CH_BEL);
                        send_word(c, chunk_end());
                    end
                    if ($urandom_range(0, 7) != 0)
                        send_word(CH_BEL, chunk_end());
                end
                8:
                begin
                    send_word(CH_ESC, chunk_end());
                    send_word($urandom_range(0, 3) == 0 ? CH_ESC : random_text_char(),
                              chunk_end());
                end
                default:
                    send_word(CP_W'($urandom_range(0, 1114111)), chunk_end());
            endcase
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes and carriage return kept at reset setting
        send_word(CP_W'(1114111), 1'b0);
        send_word('0, 1'b0);
        send_word(CH_CR, 1'b0);
        // Colour 7, then OSC skip, escape pair, zero first parameter resets
        send_text("\033[37mB", 1'b0);
        send_text("\033]x\007", 1'b0);
        send_text("\033\033", 1'b0);
        send_text("\033[0;31mE", 1'b1);

        // Carriage return dropped in plain text, ignored inside a CSI
        wait_idle();
        write_drop_cr(1'b1);
        send_text("\015\033[3\0152mF\015", 1'b1);

        // Random phases alternating the setting; last one without idling
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            write_drop_cr(ph % 2 == 0);
            quiet <= (ph == 3);
            run_random_phase(PHASE_WORDS);
            if (ph == 0)
                wait_idle();
            run_random_phase(PHASE_WORDS);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
